// ===== rtl/generational_slot_allocator_macros.svh =====
// Assertion macros for the generational slot allocator
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define GSA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSA_ASSERT(lbl, prop, msg) `GSA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define GSA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define GSA_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== rtl/gsa_pkg.sv =====
// Types, constants and helper functions shared by the slot allocator
package gsa_pkg;

  localparam int NUM_LAYOUTS = 4;
  localparam int MAX_CHUNKS  = 16;
  localparam int SLOTS       = 64;
  localparam int GEN_BITS    = 8;

  localparam int LAYOUT_W = $clog2(NUM_LAYOUTS);
  localparam int CHUNK_W  = $clog2(MAX_CHUNKS);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int INDEX_W  = CHUNK_W + SLOT_W;
  localparam int OPEN_W   = $clog2(MAX_CHUNKS + 1);
  localparam int ROW_AW   = LAYOUT_W + CHUNK_W;
  localparam int ROWS     = NUM_LAYOUTS * MAX_CHUNKS;
  localparam int CFG_W    = 3;
  localparam int ACTION_W = 2;

  localparam logic [CFG_W-1:0] LAYOUTS_RESET = 3'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SPAWN = 2'd0,
    ACT_KILL  = 2'd1,
    ACT_CHECK = 2'd2
  } action_e;

  // One chunk of one layout: generations, written marks and free bits
  typedef struct packed {
    logic [SLOTS-1:0][GEN_BITS-1:0] gens;
    logic [SLOTS-1:0]               touched;
    logic [SLOTS-1:0]               free;
  } row_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                open_new;
    logic                exhausted;
    logic                kill_ok;
    logic                check_ok;
    logic                fwd;
    logic [ROW_AW-1:0]   row;
    logic [SLOT_W-1:0]   slot;
    logic [GEN_BITS-1:0] generation;
  } op_t;

  typedef struct packed {
    logic              we;
    logic              full;
    logic [ROW_AW-1:0] addr;
    row_t              data;
  } wb_t;

  function automatic logic [SLOT_W-1:0] lowest_set(input logic [SLOTS-1:0] w);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [GEN_BITS-1:0] gen_of(input row_t r, input logic [SLOT_W-1:0] s);
    return r.touched[s] ? r.gens[s] : {GEN_BITS{1'b1}};
  endfunction

endpackage

// ===== rtl/gsa_ram.sv =====
// Generic single-port-write, registered-read RAM
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gsa_ctrl.sv =====
// Chunk tracking, spawn chunk selection and row address issue
`include "generational_slot_allocator_macros.svh"

module gsa_ctrl
  import gsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                v1_i,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [LAYOUT_W-1:0] layout_i,
  input  logic [INDEX_W-1:0]  entity_index_i,
  input  logic [GEN_BITS-1:0] generation_i,
  input  logic [CFG_W-1:0]    layouts_in_use_i,
  input  wb_t                 wb_i,
  output logic [ROW_AW-1:0]   raddr_o,
  output logic                v2_o,
  output op_t                 op_o
);

  logic [OPEN_W-1:0]     opened_q [NUM_LAYOUTS];
  logic [OPEN_W-1:0]     opened_d [NUM_LAYOUTS];
  logic [ROWS-1:0]       has_free_q;
  logic [ROWS-1:0]       has_free_d;
  logic [ROWS-1:0]       hf_eff;
  logic [MAX_CHUNKS-1:0] hf_lay;
  logic                  v2_q;
  op_t                   op_q;
  op_t                   op_d;

  logic [CHUNK_W-1:0] chunk;
  logic [CHUNK_W-1:0] found_c;
  logic [CHUNK_W-1:0] sel_chunk;
  logic [OPEN_W-1:0]  opened_cur;
  logic               found;
  logic               at_limit;
  logic               ch_open;
  logic               is_spawn;
  logic               open_go;
  logic               orphan;

  assign chunk      = entity_index_i[INDEX_W-1:SLOT_W];
  assign opened_cur = opened_q[layout_i];
  assign ch_open    = OPEN_W'(chunk) < opened_cur;
  assign at_limit   = opened_cur == OPEN_W'(MAX_CHUNKS);
  assign is_spawn   = action_i == ACT_SPAWN;

  // drop the free mark of a chunk that the older item fills
  assign hf_eff = has_free_q & ~(wb_i.full ? (ROWS'(1) << wb_i.addr) : '0);
  assign hf_lay = hf_eff[layout_i*MAX_CHUNKS +: MAX_CHUNKS];
  assign found  = |hf_lay;

  always_comb begin
    found_c = '0;
    for (int c = MAX_CHUNKS - 1; c >= 0; c--) begin
      if (hf_lay[c]) begin
        found_c = CHUNK_W'(c);
      end
    end
  end

  assign sel_chunk = found ? found_c : opened_cur[CHUNK_W-1:0];
  assign raddr_o   = {layout_i, is_spawn ? sel_chunk : chunk};
  assign open_go   = adv_i && v1_i && is_spawn && !found && !at_limit;

  always_comb begin
    op_d.action     = action_i;
    op_d.open_new   = is_spawn && !found && !at_limit;
    op_d.exhausted  = !found && at_limit;
    op_d.kill_ok    = ch_open;
    op_d.check_ok   = ch_open && (CFG_W'(layout_i) < layouts_in_use_i);
    op_d.fwd        = wb_i.we && (wb_i.addr == raddr_o);
    op_d.row        = raddr_o;
    op_d.slot       = entity_index_i[SLOT_W-1:0];
    op_d.generation = generation_i;
  end

  always_comb begin
    opened_d   = opened_q;
    has_free_d = hf_eff;
    if (v1_i) begin
      case (action_i)
        ACT_SPAWN: begin
          if (!found && !at_limit) begin
            opened_d[layout_i]  = opened_cur + OPEN_W'(1);
            has_free_d[raddr_o] = 1'b1;
          end
        end
        ACT_KILL: begin
          if (ch_open) begin
            has_free_d[raddr_o] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opened_q   <= '{default: '0};
      has_free_q <= '0;
      v2_q       <= 1'b0;
    end else if (adv_i) begin
      opened_q   <= opened_d;
      has_free_q <= has_free_d;
      v2_q       <= v1_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op_q <= op_d;
    end
  end

  assign v2_o = v2_q;
  assign op_o = op_q;

  always_comb begin
    logic [ROW_AW-1:0] rr;
    orphan = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      rr = ROW_AW'(r);
      if (has_free_q[r] && (OPEN_W'(rr[CHUNK_W-1:0]) >= opened_q[rr[ROW_AW-1:CHUNK_W]])) begin
        orphan = 1'b1;
      end
    end
  end

  `GSA_ASSERT(a_free_mark_opened, !orphan, "free mark on a chunk that is not open")
  `GSA_ASSERT(a_open_marks_free, open_go |=> has_free_q[$past(raddr_o)], "opened chunk not free")
  `GSA_ASSERT(a_limit_holds, v1_i && is_spawn && op_d.exhausted |-> !found && at_limit, "bad exhaust")

endmodule

// ===== rtl/gsa_slot.sv =====
// Row update, result computation and result register
`include "generational_slot_allocator_macros.svh"

module gsa_slot
  import gsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                v2_i,
  input  op_t                 op_i,
  input  row_t                rdata_i,
  output wb_t                 wb_o,
  output logic                out_valid_o,
  output logic                status_o,
  output logic [INDEX_W-1:0]  new_index_o,
  output logic [GEN_BITS-1:0] new_generation_o,
  output logic                live_o
);

  row_t                fwd_row_q;
  row_t                fresh;
  row_t                base;
  logic [SLOT_W-1:0]   sp_slot;
  logic [SLOT_W-1:0]   sel_slot;
  logic [GEN_BITS-1:0] g_cur;
  logic                spawn_ok;

  logic                out_valid_q;
  logic                status_q;
  logic                status_d;
  logic [INDEX_W-1:0]  index_q;
  logic [INDEX_W-1:0]  index_d;
  logic [GEN_BITS-1:0] gen_q;
  logic [GEN_BITS-1:0] gen_d;
  logic                live_q;
  logic                live_d;

  always_comb begin
    fresh.gens    = '1;
    fresh.touched = '0;
    fresh.free    = '1;
  end

  always_comb begin
    if (op_i.open_new) begin
      base = fresh;
    end else if (op_i.fwd) begin
      base = fwd_row_q;
    end else begin
      base = rdata_i;
    end
  end

  assign spawn_ok = (op_i.action == ACT_SPAWN) && !op_i.exhausted;
  assign sp_slot  = lowest_set(base.free);
  assign sel_slot = (op_i.action == ACT_SPAWN) ? sp_slot : op_i.slot;
  assign g_cur    = gen_of(base, sel_slot);

  always_comb begin
    wb_o.we   = 1'b0;
    wb_o.full = 1'b0;
    wb_o.addr = op_i.row;
    wb_o.data = base;
    status_d  = 1'b0;
    index_d   = '0;
    gen_d     = '0;
    live_d    = 1'b0;
    case (op_i.action)
      ACT_SPAWN: begin
        status_d = op_i.exhausted;
        if (!op_i.exhausted) begin
          wb_o.data.free[sp_slot] = 1'b0;
          wb_o.we   = v2_i;
          wb_o.full = v2_i && (wb_o.data.free == '0);
          index_d   = {op_i.row[CHUNK_W-1:0], sp_slot};
          gen_d     = g_cur;
        end
      end
      ACT_KILL: begin
        if (op_i.kill_ok) begin
          wb_o.data.gens[sel_slot]    = g_cur + GEN_BITS'(1);
          wb_o.data.touched[sel_slot] = 1'b1;
          wb_o.data.free[sel_slot]    = 1'b1;
          wb_o.we = v2_i;
        end
      end
      ACT_CHECK: begin
        live_d = op_i.check_ok && (g_cur == op_i.generation) && !base.free[sel_slot];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && wb_o.we) begin
      fwd_row_q <= wb_o.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= v2_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      status_q <= status_d;
      index_q  <= index_d;
      gen_q    <= gen_d;
      live_q   <= live_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign new_index_o      = index_q;
  assign new_generation_o = gen_q;
  assign live_o           = live_q;

  `GSA_ASSERT(a_spawn_slot_free, v2_i && spawn_ok |-> base.free[sp_slot], "spawn took a used slot")

endmodule

// ===== rtl/generational_slot_allocator.sv =====
// A result is offered once its item has passed the input, control and result registers.
// Throughput: one item per cycle when the output is not stalled; one chunk row read per item
// from the row memory, with the row written by the item ahead forwarded from a register.
// Reset: chunk counts, free marks, valids clear; layouts_in_use returns to 4.
// The row memory needs no clearing pass: a row is written whole when its chunk opens.
`include "generational_slot_allocator_macros.svh"

module generational_slot_allocator
  import gsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [LAYOUT_W-1:0] layout_i,
  input  logic [INDEX_W-1:0]  entity_index_i,
  input  logic [GEN_BITS-1:0] generation_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                status_o,
  output logic [INDEX_W-1:0]  new_index_o,
  output logic [GEN_BITS-1:0] new_generation_o,
  output logic                live_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  logic                adv;
  logic [CFG_W-1:0]    layouts_q;
  logic                v1_q;
  logic [ACTION_W-1:0] action_q;
  logic [LAYOUT_W-1:0] layout_q;
  logic [INDEX_W-1:0]  index_q;
  logic [GEN_BITS-1:0] gen_q;

  logic [ROW_AW-1:0]   raddr;
  logic                v2;
  op_t                 op;
  wb_t                 wb;
  row_t                rdata;

  assign adv         = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layouts_q <= LAYOUTS_RESET;
      v1_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        layouts_q <= cfg_data_i;
      end
      if (adv) begin
        v1_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      action_q <= action_i;
      layout_q <= layout_i;
      index_q  <= entity_index_i;
      gen_q    <= generation_i;
    end
  end

  gsa_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .v1_i            (v1_q),
    .action_i        (action_q),
    .layout_i        (layout_q),
    .entity_index_i  (index_q),
    .generation_i    (gen_q),
    .layouts_in_use_i(layouts_q),
    .wb_i            (wb),
    .raddr_o         (raddr),
    .v2_o            (v2),
    .op_o            (op)
  );

  gsa_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(ROWS)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (adv && wb.we),
    .waddr_i(wb.addr),
    .wdata_i(wb.data),
    .re_i   (adv),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  gsa_slot u_slot (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .v2_i            (v2),
    .op_i            (op),
    .rdata_i         (rdata),
    .wb_o            (wb),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .new_index_o     (new_index_o),
    .new_generation_o(new_generation_o),
    .live_o          (live_o)
  );

endmodule
